// ===== rtl/core/itrd_pkg.sv =====
// Shared types, constants and helper functions for the integer-to-radix-digits core.
// No dependencies; compiled first.
`default_nettype none

package itrd_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

    localparam logic [RADIX_W-1:0] DIGIT_LIMIT   = RADIX_W'(9);
    localparam logic [RADIX_W-1:0] LETTER_OFFSET = RADIX_W'(10);
    localparam logic [CHAR_W-1:0]  LETTER_BASE   = CHAR_W'(65);  // 'A'
    localparam logic [CHAR_W-1:0]  NUMERAL_BASE  = CHAR_W'(48);  // '0'

    typedef logic [RADIX_W-1:0] t_digit;
    typedef logic [CHAR_W-1:0]  t_char;

    // Out-of-range bases fold to the nearest legal one.
    function automatic t_digit effective_radix(input t_digit radix);
        t_digit res;
        if (radix < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (radix > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = radix;
        end
        return res;
    endfunction

    function automatic t_char digit_to_ascii(input t_digit d);
        t_char res;
        if (d > DIGIT_LIMIT) begin
            res = LETTER_BASE + CHAR_W'(d - LETTER_OFFSET);
        end else begin
            res = NUMERAL_BASE + CHAR_W'(d);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/itrd_cfg_if.sv =====
// Configuration write channel: valid/ready plus the radix write data.
// Depends on itrd_pkg.
`default_nettype none

interface itrd_cfg_if import itrd_pkg::*; ();
    logic   valid;
    logic   ready;
    t_digit radix;

    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/itrd_in_if.sv =====
// Input stream channel: valid/ready plus the integer to convert.
// Depends on itrd_pkg.
`default_nettype none

interface itrd_in_if import itrd_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/itrd_out_if.sv =====
// Output stream channel: valid/ready plus one ASCII digit and its last flag.
// Depends on itrd_pkg.
`default_nettype none

interface itrd_out_if import itrd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_char digit_char;
    logic  last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/integer_to_radix_digits_core.sv =====
// Top level of the integer-to-radix-digits converter.
// Depends on itrd_pkg and the itrd_cfg_if / itrd_in_if / itrd_out_if interfaces.
`default_nettype none

// Converts one unsigned VALUE_BITS-bit integer per input transaction into its
// digits in the base held in the radix register (reset value 10; 0 and 1 act
// as 2, 37 and above act as 36) and emits them most significant first, one
// output transaction per digit, as ASCII '0'-'9' then 'A'-'Z'; the final
// (least significant) digit has last_digit set, and zero gives a single '0'.
// Conversion is repeated division by the base, done as a bit-serial
// restoring divider: one quotient bit per cycle, with one division pass per
// digit; the remainders are stacked and then emitted. One item is converted
// at a time. The input is ready whenever the converter is idle, even while
// the last digit of the previous item still waits in the output register.
// The radix channel is always ready; write it only while the block is idle.

module integer_to_radix_digits_core import itrd_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    itrd_cfg_if.sink     i_cfg,
    itrd_in_if.sink      i_in,
    itrd_out_if.source   o_out
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                r_state;
    t_digit                r_radix;      // configuration register
    t_digit                r_base;       // base latched for the current item
    logic [VALUE_BITS-1:0] r_num;        // dividend shifting out, quotient shifting in
    t_digit                r_rem;        // partial remainder
    logic [CNT_W-1:0]      r_bit;        // quotient bits left in this pass, minus one
    logic [CNT_W-1:0]      r_cnt;        // digits held in the stack
    t_digit                r_stack [VALUE_BITS];  // LIFO, top at index 0

    logic                  r_out_valid;
    t_char                 r_out_char;
    logic                  r_out_last;

    // One restoring-division step.
    logic [RADIX_W:0]      trial;
    logic [RADIX_W:0]      base_ext;
    logic [RADIX_W:0]      diff;
    logic                  q_bit;
    t_digit                n_rem;
    logic [VALUE_BITS-1:0] n_num;
    logic                  out_free;
    logic                  emit_now;

    assign trial    = {r_rem, r_num[VALUE_BITS-1]};
    assign base_ext = {1'b0, r_base};
    assign diff     = trial - base_ext;
    assign q_bit    = (trial >= base_ext);
    assign n_rem    = q_bit ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
    assign n_num    = {r_num[VALUE_BITS-2:0], q_bit};

    assign out_free = !r_out_valid || o_out.ready;
    // A digit moves into the output register this cycle.
    assign emit_now = (r_state == S_EMIT) && out_free;

    assign i_cfg.ready      = 1'b1;
    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.digit_char = r_out_char;
    assign o_out.last_digit = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix     <= RADIX_RESET;
            r_cnt       <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_radix <= i_cfg.radix;
            end

            if (emit_now) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_num   <= i_in.value;
                        r_rem   <= '0;
                        r_base  <= effective_radix(r_radix);
                        r_bit   <= CNT_W'(VALUE_BITS - 1);
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end

                S_DIV: begin
                    if (r_bit == '0) begin
                        // Pass done: push the remainder, keep dividing the quotient.
                        r_stack[0] <= n_rem;
                        for (int k = 1; k < VALUE_BITS; k++) begin
                            r_stack[k] <= r_stack[k-1];
                        end
                        r_cnt <= r_cnt + CNT_W'(1);
                        r_num <= n_num;
                        r_rem <= '0;
                        r_bit <= CNT_W'(VALUE_BITS - 1);
                        if (n_num == '0) begin
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_num <= n_num;
                        r_rem <= n_rem;
                        r_bit <= r_bit - CNT_W'(1);
                    end
                end

                S_EMIT: begin
                    if (emit_now) begin
                        r_out_char  <= digit_to_ascii(r_stack[0]);
                        r_out_last  <= (r_cnt == CNT_W'(1));
                        for (int k = 0; k < VALUE_BITS - 1; k++) begin
                            r_stack[k] <= r_stack[k+1];
                        end
                        r_cnt <= r_cnt - CNT_W'(1);
                        if (r_cnt == CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== tb/integer_to_radix_digits_core_tb.sv =====
// Self-checking testbench for integer_to_radix_digits_core: random and directed values
// across many radix settings, digits checked against an in-bench predictor.
// Depends on itrd_pkg and the itrd_cfg_if / itrd_in_if / itrd_out_if interfaces.
`timescale 1ns / 1ps

module integer_to_radix_digits_core_tb;
    import itrd_pkg::*;

    localparam int VB           = VALUE_BITS_DEF;
    localparam int RANDOM_SETS  = 9;
    localparam int SET_ITEMS    = 40;
    localparam int HOLD_CYCLES  = 400;
    // Slowest legal run: about 383 values, each of up to 31 division passes
    // and 31 digits at a mostly idle receiver, plus one long hold-off; this
    // limit is several times as long.
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int TAIL_CYCLES  = 64;

    // Predicts the digit string of each accepted value and checks the digit stream.
    class radix_digit_scoreboard;
        typedef struct packed {
            t_char ch;
            logic  last;
        } t_sb_digit;

        t_digit    radix_reg;
        t_sb_digit pending_digits[$];
        int        errors;

        function new();
            radix_reg = RADIX_RESET;
            errors    = 0;
        endfunction

        function void set_radix(t_digit r);
            radix_reg = r;
        endfunction

        function int pending_count();
            return pending_digits.size();
        endfunction

        function t_char ascii_of(int unsigned d);
            if (d > 9) begin
                return LETTER_BASE + t_char'(d - 10);
            end
            return NUMERAL_BASE + t_char'(d);
        endfunction

        // Repeated division, remainders collected least significant first.
        function void note_value(logic [VB-1:0] v);
            int unsigned base;
            int unsigned num;
            t_char       rev[$];
            t_sb_digit   d;
            if (radix_reg < RADIX_MIN) begin
                base = RADIX_MIN;
            end else if (radix_reg > RADIX_MAX) begin
                base = RADIX_MAX;
            end else begin
                base = radix_reg;
            end
            num = v;
            do begin
                rev.push_front(ascii_of(num % base));
                num = num / base;
            end while (num != 0);
            foreach (rev[i]) begin
                d.ch   = rev[i];
                d.last = (i == rev.size() - 1);
                pending_digits.push_back(d);
            end
        endfunction

        function void check_digit(t_char ch, logic last);
            t_sb_digit exp_d;
            if (pending_digits.size() == 0) begin
                $error("unexpected digit transaction: digit_char=%0d last_digit=%0d", ch, last);
                errors++;
                return;
            end
            exp_d = pending_digits.pop_front();
            if (ch !== exp_d.ch) begin
                $error("digit_char mismatch: expected %0d actual %0d", exp_d.ch, ch);
                errors++;
            end
            if (last !== exp_d.last) begin
                $error("last_digit mismatch: expected %0d actual %0d", exp_d.last, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    itrd_cfg_if                    cfg_if ();
    itrd_in_if #(.VALUE_BITS(VB))  in_if ();
    itrd_out_if                    out_if ();

    integer_to_radix_digits_core #(
        .VALUE_BITS(VB)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    radix_digit_scoreboard book;

    // Idle percentages for each side, changed by the stimulus between sets.
    int send_idle = 0;
    int recv_idle = 0;
    // Asks the receiver process to hold off for a long stretch.
    bit hold_req  = 1'b0;
    int cycle_count = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: the run never legitimately gets anywhere near this.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Digit receiver: checks each accepted digit transaction, then picks the
    // next ready level (random stall, or a long hold-off when asked).
    initial begin
        int hold_left;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                book.check_digit(out_if.digit_char, out_if.last_digit);
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // Offers one value and returns at the edge where it is accepted. Valid is
    // left high so back-to-back values need no low cycle; callers lower it.
    task automatic send_value(input logic [VB-1:0] v);
        while ($urandom_range(99) < send_idle) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= v;
        do @(posedge i_clk); while (!in_if.ready);
        book.note_value(v);
    endtask

    // Stops offering values and waits for every predicted digit to arrive.
    task automatic drain_digits();
        in_if.valid <= 1'b0;
        while (book.pending_count() != 0) @(posedge i_clk);
    endtask

    // Radix writes happen only with the converter idle.
    task automatic write_radix(input t_digit r);
        drain_digits();
        repeat (4) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.radix <= r;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        book.set_radix(r);
    endtask

    // Mostly short values (division cost scales with digit count), plus
    // the extremes and random patterns shifted down to a random width.
    function automatic logic [VB-1:0] random_value();
        logic [VB-1:0] v;
        case ($urandom_range(9))
            0: v = '0;
            1: v = '1;
            2, 3, 4: v = VB'($urandom_range(0, 1000));
            default: v = VB'($urandom) >> $urandom_range(0, VB - 1);
        endcase
        return v;
    endfunction

    initial begin
        t_digit set_radix_list[RANDOM_SETS];
        book = new();
        set_radix_list = '{6'd2, 6'd36, 6'd16, 6'd63, 6'd7, 6'd1, 6'd0, 6'd10, 6'd23};
        set_radix_list[RANDOM_SETS - 1] = t_digit'($urandom_range(0, 63));

        i_rst_n      <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.radix <= RADIX_RESET;
        in_if.valid  <= 1'b0;
        in_if.value  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 22;
        recv_idle = 80;

        // Directed: reset radix (10), zero, one, the 9/10 digit-count boundary, full scale.
        send_value(VB'(0));
        send_value(VB'(1));
        send_value(VB'(9));
        send_value(VB'(10));
        send_value('1);
        send_value(VB'(1000000000));
        // Radix below two folds to binary.
        write_radix(6'd0);
        send_value(VB'(0));
        send_value(VB'(1));
        send_value('1);
        send_value(VB'(31'h2AAAAAAA));
        write_radix(6'd1);
        send_value(VB'(2));
        send_value(VB'(3));
        // Top legal radix: 'Z' and carry into the next digit.
        write_radix(6'd36);
        send_value(VB'(35));
        send_value(VB'(36));
        send_value(VB'(1295));
        send_value('1);
        // Radix above thirty-six folds to 36.
        write_radix(6'd37);
        send_value(VB'(35));
        send_value(VB'(36));
        write_radix(6'd63);
        send_value(VB'(46655));
        send_value(VB'(0));
        write_radix(6'd16);
        send_value(VB'(255));
        send_value(VB'(256));
        send_value('1);

        // Random sets, one radix each; idling pattern changes every three sets.
        for (int s = 0; s < RANDOM_SETS; s++) begin
            if (s < 3) begin
                send_idle = 22;
                recv_idle = 80;
            end else if (s < 6) begin
                send_idle = 80;
                recv_idle = 22;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_radix(set_radix_list[s]);
            for (int k = 0; k < SET_ITEMS; k++) begin
                // Long receiver hold-off while values keep coming: the
                // converter backs up and stalls its input.
                if (s == 7 && k == 0) begin
                    hold_req = 1'b1;
                end
                // Sender pause mid-set until the block has emptied.
                if (s == 5 && k == SET_ITEMS / 2) begin
                    drain_digits();
                end
                send_value(random_value());
            end
        end

        drain_digits();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (book.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
